/* rtl/core/pdfa_pkg.sv */
// shared types and constants of the programmable dfa matcher
package pdfa_pkg;

   // default sizes
   localparam int NUM_STATES_DEF  = 16;
   localparam int SYMBOL_BITS_DEF = 8;

   // fixed field widths
   localparam int OPCODE_W = 3;
   localparam int SYM_W    = 8;
   localparam int STATE_W  = 4;
   localparam int STATUS_W = 2;
   localparam int MASK_W   = 16;
   localparam int CSR_AW   = 3;
   localparam int CSR_DW   = 32;

   typedef enum logic [OPCODE_W-1:0] {
      OP_ADD_SYMBOL = 3'd0,
      OP_WRITE      = 3'd1,
      OP_WRITE_ALL  = 3'd2,
      OP_FEED       = 3'd3,
      OP_END        = 3'd4
   } opcode_type;

   typedef enum logic [STATUS_W-1:0] {
      ST_DONE    = 2'd0,
      ST_REFUSED = 2'd1,
      ST_VERDICT = 2'd2
   } status_type;

   typedef enum logic {
      REG_START_STATE = 1'b0,
      REG_FINAL_MASK  = 1'b1
   } reg_index_type;

   // memory strobes from the engine to the store
   typedef struct packed {
      logic alpha_we;
      logic alpha_re;
      logic tbl_we;
      logic tbl_re;
   } mem_ctl_type;

   // one transition table entry
   typedef struct packed {
      logic               valid;
      logic [STATE_W-1:0] target;
   } entry_type;

   // finished result handed to the output register
   typedef struct packed {
      logic       valid;
      status_type status;
      logic       accepted;
   } result_type;

endpackage

/* rtl/core/pdfa_csr.sv */
// apb configuration registers: start state and final state mask
module pdfa_csr import pdfa_pkg::*; (
   input  logic                clock,
   input  logic                reset,
   input  logic                csr_psel,
   input  logic                csr_penable,
   input  logic                csr_pwrite,
   input  logic [CSR_AW-1:0]   csr_paddr,
   input  logic [CSR_DW-1:0]   csr_pwdata,
   output logic [CSR_DW-1:0]   csr_prdata,
   output logic                csr_pready,
   output logic [STATE_W-1:0]  start_state,
   output logic [MASK_W-1:0]   final_mask,
   output logic                restart,
   output logic [STATE_W-1:0]  restart_state
);

   logic [STATE_W-1:0] start_state_ff;
   logic [MASK_W-1:0]  final_mask_ff;
   reg_index_type      reg_index;
   logic               wr_en;

   // register select by word address
   assign reg_index  = reg_index_type'(csr_paddr[2]);
   assign wr_en      = csr_psel && csr_penable && csr_pwrite;
   assign csr_pready = 1'b1;

   // a start state write also restarts any word in progress
   assign restart       = wr_en && (reg_index == REG_START_STATE);
   assign restart_state = csr_pwdata[STATE_W-1:0];

   // register writes
   always_ff @(posedge clock) begin
      if (reset) begin
         start_state_ff <= '0;
         final_mask_ff  <= '0;
      end else if (wr_en) begin
         unique case (reg_index)
            REG_START_STATE: start_state_ff <= csr_pwdata[STATE_W-1:0];
            REG_FINAL_MASK:  final_mask_ff  <= csr_pwdata[MASK_W-1:0];
         endcase
      end
   end

   // read back
   always_comb begin
      unique case (reg_index)
         REG_START_STATE: csr_prdata = CSR_DW'(start_state_ff);
         REG_FINAL_MASK:  csr_prdata = CSR_DW'(final_mask_ff);
      endcase
   end

   assign start_state = start_state_ff;
   assign final_mask  = final_mask_ff;

endmodule

/* rtl/core/pdfa_store.sv */
// alphabet and transition memories with the clearing sweep after reset
module pdfa_store import pdfa_pkg::*; #(
   parameter int NUM_STATES  = NUM_STATES_DEF,
   parameter int SYMBOL_BITS = SYMBOL_BITS_DEF
) (
   input  logic                                         clock,
   input  logic                                         reset,
   input  mem_ctl_type                                  mem_ctl,
   input  logic [SYMBOL_BITS-1:0]                       alpha_addr,
   input  logic [$clog2(NUM_STATES)+SYMBOL_BITS-1:0]    tbl_addr,
   input  entry_type                                    tbl_wdata,
   output logic                                         alpha_rdata,
   output entry_type                                    tbl_rdata,
   output logic                                         clear_busy
);

   localparam int SIDX_W      = $clog2(NUM_STATES);
   localparam int TBL_AW      = SIDX_W + SYMBOL_BITS;
   localparam int ALPHA_DEPTH = 1 << SYMBOL_BITS;
   localparam int TBL_DEPTH   = NUM_STATES * ALPHA_DEPTH;
   localparam logic [TBL_AW-1:0] CLR_LAST = TBL_AW'(TBL_DEPTH - 1);

   logic      alpha_mem [ALPHA_DEPTH];
   entry_type tbl_mem   [TBL_DEPTH];

   logic              clr_busy_ff;
   logic [TBL_AW-1:0] clr_cnt_ff;
   logic              alpha_rdata_ff;
   entry_type         tbl_rdata_ff;

   logic                   alpha_we;
   logic [SYMBOL_BITS-1:0] alpha_waddr;
   logic                   alpha_wdata;
   logic                   tbl_we;
   logic [TBL_AW-1:0]      tbl_waddr;
   entry_type              tbl_wd;

   // clearing sweep, one entry a cycle
   always_ff @(posedge clock) begin
      if (reset) begin
         clr_busy_ff <= 1'b1;
         clr_cnt_ff  <= '0;
      end else if (clr_busy_ff) begin
         clr_cnt_ff <= clr_cnt_ff + TBL_AW'(1);
         if (clr_cnt_ff == CLR_LAST) begin
            clr_busy_ff <= 1'b0;
         end
      end
   end

   // write port select: sweep or engine
   always_comb begin
      if (clr_busy_ff) begin
         alpha_we    = 1'b1;
         alpha_waddr = clr_cnt_ff[SYMBOL_BITS-1:0];
         alpha_wdata = 1'b0;
         tbl_we      = 1'b1;
         tbl_waddr   = clr_cnt_ff;
         tbl_wd      = '0;
      end else begin
         alpha_we    = mem_ctl.alpha_we;
         alpha_waddr = alpha_addr;
         alpha_wdata = 1'b1;
         tbl_we      = mem_ctl.tbl_we;
         tbl_waddr   = tbl_addr;
         tbl_wd      = tbl_wdata;
      end
   end

   // alphabet memory
   always_ff @(posedge clock) begin
      if (alpha_we) begin
         alpha_mem[alpha_waddr] <= alpha_wdata;
      end
      if (mem_ctl.alpha_re) begin
         alpha_rdata_ff <= alpha_mem[alpha_addr];
      end
   end

   // transition memory
   always_ff @(posedge clock) begin
      if (tbl_we) begin
         tbl_mem[tbl_waddr] <= tbl_wd;
      end
      if (mem_ctl.tbl_re) begin
         tbl_rdata_ff <= tbl_mem[tbl_addr];
      end
   end

   assign alpha_rdata = alpha_rdata_ff;
   assign tbl_rdata   = tbl_rdata_ff;
   assign clear_busy  = clr_busy_ff;

endmodule

/* rtl/core/pdfa_engine.sv */
// item sequencer: decodes transactions, walks the alphabet, steps the automaton
module pdfa_engine import pdfa_pkg::*; #(
   parameter int NUM_STATES  = NUM_STATES_DEF,
   parameter int SYMBOL_BITS = SYMBOL_BITS_DEF
) (
   input  logic                                         clock,
   input  logic                                         reset,
   input  logic                                         req_valid,
   output logic                                         req_stall,
   input  logic [OPCODE_W-1:0]                          req_opcode,
   input  logic [SYM_W-1:0]                             req_symbol,
   input  logic [STATE_W-1:0]                           req_from_state,
   input  logic [STATE_W-1:0]                           req_to_state,
   input  logic [STATE_W-1:0]                           start_state,
   input  logic [MASK_W-1:0]                            final_mask,
   input  logic                                         restart,
   input  logic [STATE_W-1:0]                           restart_state,
   input  logic                                         clear_busy,
   input  logic                                         out_free,
   output result_type                                   fin,
   output mem_ctl_type                                  mem_ctl,
   output logic [SYMBOL_BITS-1:0]                       alpha_addr,
   output logic [$clog2(NUM_STATES)+SYMBOL_BITS-1:0]    tbl_addr,
   output entry_type                                    tbl_wdata,
   input  logic                                         alpha_rdata,
   input  entry_type                                    tbl_rdata
);

   localparam int SIDX_W = $clog2(NUM_STATES);
   localparam logic [SYMBOL_BITS-1:0] SYM_LAST = '1;

   typedef enum logic [2:0] {
      S_IDLE,
      S_WR_CHK,
      S_ALL_WALK,
      S_FEED_LOOK,
      S_HOLD
   } eng_state_type;

   eng_state_type          state_ff, state_in;
   logic [SIDX_W-1:0]      from_ff, from_in;
   logic [STATE_W-1:0]     to_ff, to_in;
   logic [SYMBOL_BITS-1:0] sym_ff, sym_in;
   logic [SYMBOL_BITS-1:0] walk_ff, walk_in;
   logic [STATE_W-1:0]     cur_ff, cur_in;
   logic                   dead_ff, dead_in;
   status_type             hold_status_ff, hold_status_in;
   logic                   hold_acc_ff, hold_acc_in;

   logic                   ready;
   logic                   accept;
   logic [SYMBOL_BITS-1:0] op_sym;
   logic                   req_range_bad;
   logic                   cur_bad;
   logic                   done_now;
   status_type             res_status;
   logic                   res_acc;

   assign ready     = (state_ff == S_IDLE) && !clear_busy;
   assign accept    = req_valid && ready;
   assign req_stall = !ready;
   assign op_sym    = req_symbol[SYMBOL_BITS-1:0];

   // state indices are range checked against the configured state count
   assign req_range_bad = (32'(req_from_state) >= 32'(NUM_STATES)) ||
                          (32'(req_to_state) >= 32'(NUM_STATES));
   assign cur_bad       = 32'(cur_ff) >= 32'(NUM_STATES);

   // next state and memory strobes
   always_comb begin
      state_in       = state_ff;
      from_in        = from_ff;
      to_in          = to_ff;
      sym_in         = sym_ff;
      walk_in        = walk_ff;
      cur_in         = cur_ff;
      dead_in        = dead_ff;
      hold_status_in = hold_status_ff;
      hold_acc_in    = hold_acc_ff;
      mem_ctl        = '0;
      alpha_addr     = op_sym;
      tbl_addr       = {SIDX_W'(cur_ff), op_sym};
      tbl_wdata      = '{valid: 1'b1, target: to_ff};
      done_now       = 1'b0;
      res_status     = ST_DONE;
      res_acc        = 1'b0;
      fin            = '{valid: 1'b0, status: ST_DONE, accepted: 1'b0};

      unique case (state_ff)
         S_IDLE: begin
            if (accept) begin
               sym_in  = op_sym;
               from_in = SIDX_W'(req_from_state);
               to_in   = req_to_state;
               unique case (req_opcode)
                  OP_ADD_SYMBOL: begin
                     mem_ctl.alpha_we = 1'b1;
                     done_now         = 1'b1;
                  end
                  OP_WRITE: begin
                     if (req_range_bad) begin
                        res_status = ST_REFUSED;
                        done_now   = 1'b1;
                     end else begin
                        mem_ctl.alpha_re = 1'b1;
                        state_in         = S_WR_CHK;
                     end
                  end
                  OP_WRITE_ALL: begin
                     if (req_range_bad) begin
                        res_status = ST_REFUSED;
                        done_now   = 1'b1;
                     end else begin
                        mem_ctl.alpha_re = 1'b1;
                        alpha_addr       = '0;
                        walk_in          = '0;
                        state_in         = S_ALL_WALK;
                     end
                  end
                  OP_FEED: begin
                     if (dead_ff) begin
                        done_now = 1'b1;
                     end else if (cur_bad) begin
                        dead_in  = 1'b1;
                        done_now = 1'b1;
                     end else begin
                        mem_ctl.tbl_re = 1'b1;
                        state_in       = S_FEED_LOOK;
                     end
                  end
                  OP_END: begin
                     res_status = ST_VERDICT;
                     res_acc    = !dead_ff && final_mask[cur_ff];
                     cur_in     = start_state;
                     dead_in    = 1'b0;
                     done_now   = 1'b1;
                  end
                  default: begin
                     done_now = 1'b1;
                  end
               endcase
            end
         end
         // single write: alphabet bit is back
         S_WR_CHK: begin
            tbl_addr = {from_ff, sym_ff};
            if (alpha_rdata) begin
               mem_ctl.tbl_we = 1'b1;
            end else begin
               res_status = ST_REFUSED;
            end
            done_now = 1'b1;
         end
         // all write: write the symbol just read, fetch the next one
         S_ALL_WALK: begin
            tbl_addr       = {from_ff, walk_ff};
            mem_ctl.tbl_we = alpha_rdata;
            if (walk_ff == SYM_LAST) begin
               done_now = 1'b1;
            end else begin
               mem_ctl.alpha_re = 1'b1;
               alpha_addr       = walk_ff + SYMBOL_BITS'(1);
               walk_in          = walk_ff + SYMBOL_BITS'(1);
            end
         end
         // feed: table entry is back
         S_FEED_LOOK: begin
            if (tbl_rdata.valid) begin
               cur_in = tbl_rdata.target;
            end else begin
               dead_in = 1'b1;
            end
            done_now = 1'b1;
         end
         // result waits for the output register
         S_HOLD: begin
            if (out_free) begin
               fin      = '{valid: 1'b1, status: hold_status_ff, accepted: hold_acc_ff};
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase

      // hand over the finished result or park it
      if (done_now) begin
         if (out_free) begin
            fin      = '{valid: 1'b1, status: res_status, accepted: res_acc};
            state_in = S_IDLE;
         end else begin
            hold_status_in = res_status;
            hold_acc_in    = res_acc;
            state_in       = S_HOLD;
         end
      end

      // start state rewrite restarts the word
      if (restart) begin
         cur_in  = restart_state;
         dead_in = 1'b0;
      end
   end

   // state and registered values
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         cur_ff   <= '0;
         dead_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         cur_ff   <= cur_in;
         dead_ff  <= dead_in;
      end
      from_ff        <= from_in;
      to_ff          <= to_in;
      sym_ff         <= sym_in;
      walk_ff        <= walk_in;
      hold_status_ff <= hold_status_in;
      hold_acc_ff    <= hold_acc_in;
   end

`ifndef NO_ASSERTIONS
   // the dead condition is only entered by a fed symbol
   a_dead_from_feed: assert property (@(posedge clock) disable iff (reset)
      $rose(dead_ff) |-> $past(state_ff == S_FEED_LOOK ||
                               (accept && req_opcode == OP_FEED)))
      else $error("dead condition entered outside a feed");

   // a verdict always leaves a fresh word behind
   a_verdict_restarts: assert property (@(posedge clock) disable iff (reset)
      fin.valid && fin.status == ST_VERDICT |=> !dead_ff)
      else $error("word not restarted after verdict");

   // a result is never handed over into a full output register
   a_fin_needs_room: assert property (@(posedge clock) disable iff (reset)
      fin.valid |-> out_free)
      else $error("result lost on full output register");

   // a parked result stays put until it can leave
   a_hold_stable: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_HOLD && !out_free |=>
         state_ff == S_HOLD && $stable(hold_status_ff) && $stable(hold_acc_ff))
      else $error("parked result changed");

   // no table write while waiting for a new transaction
   a_idle_no_write: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_IDLE |-> !mem_ctl.tbl_we)
      else $error("table write from idle");
`endif

endmodule

/* rtl/core/programmable_dfa_matcher_core.sv */
// top level of the programmable dfa matcher
// Programmable DFA acceptor. After reset the transition and alphabet memories
// are swept clear over all NUM_STATES * 2**SYMBOL_BITS table entries, during
// which req_stall stays high; configuration writes are taken throughout. One
// transaction is worked at a time on a single-port transition memory with a
// registered read: add symbol, end word, unused opcodes, writes refused for a
// state out of range and fed symbols on a dead word finish straight from idle,
// a single transition write (taken or refused for its symbol) and a fed symbol
// on a live word do an alphabet or table read, then a write or state update,
// and an ALL write walks every alphabet code, writing the transition for each
// code in the alphabet. Results sit in an output register, so the next
// transaction is taken while a result waits.
module programmable_dfa_matcher_core import pdfa_pkg::*; #(
   parameter int NUM_STATES  = NUM_STATES_DEF,
   parameter int SYMBOL_BITS = SYMBOL_BITS_DEF
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_stall,
   input  logic [OPCODE_W-1:0]  req_opcode,
   input  logic [SYM_W-1:0]     req_symbol,
   input  logic [STATE_W-1:0]   req_from_state,
   input  logic [STATE_W-1:0]   req_to_state,
   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   output logic [STATUS_W-1:0]  rsp_status,
   output logic                 rsp_accepted,
   input  logic                 csr_psel,
   input  logic                 csr_penable,
   input  logic                 csr_pwrite,
   input  logic [CSR_AW-1:0]    csr_paddr,
   input  logic [CSR_DW-1:0]    csr_pwdata,
   output logic [CSR_DW-1:0]    csr_prdata,
   output logic                 csr_pready
);

   localparam int TBL_AW = $clog2(NUM_STATES) + SYMBOL_BITS;

   logic [STATE_W-1:0]     start_state;
   logic [MASK_W-1:0]      final_mask;
   logic                   restart;
   logic [STATE_W-1:0]     restart_state;
   mem_ctl_type            mem_ctl;
   logic [SYMBOL_BITS-1:0] alpha_addr;
   logic [TBL_AW-1:0]      tbl_addr;
   entry_type              tbl_wdata;
   logic                   alpha_rdata;
   entry_type              tbl_rdata;
   logic                   clear_busy;
   logic                   out_free;
   result_type             fin;

   logic                   rsp_valid_ff;
   status_type             rsp_status_ff;
   logic                   rsp_accepted_ff;

   pdfa_csr u_csr (
      .clock         (clock),
      .reset         (reset),
      .csr_psel      (csr_psel),
      .csr_penable   (csr_penable),
      .csr_pwrite    (csr_pwrite),
      .csr_paddr     (csr_paddr),
      .csr_pwdata    (csr_pwdata),
      .csr_prdata    (csr_prdata),
      .csr_pready    (csr_pready),
      .start_state   (start_state),
      .final_mask    (final_mask),
      .restart       (restart),
      .restart_state (restart_state)
   );

   pdfa_store #(
      .NUM_STATES  (NUM_STATES),
      .SYMBOL_BITS (SYMBOL_BITS)
   ) u_store (
      .clock       (clock),
      .reset       (reset),
      .mem_ctl     (mem_ctl),
      .alpha_addr  (alpha_addr),
      .tbl_addr    (tbl_addr),
      .tbl_wdata   (tbl_wdata),
      .alpha_rdata (alpha_rdata),
      .tbl_rdata   (tbl_rdata),
      .clear_busy  (clear_busy)
   );

   pdfa_engine #(
      .NUM_STATES  (NUM_STATES),
      .SYMBOL_BITS (SYMBOL_BITS)
   ) u_engine (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_opcode     (req_opcode),
      .req_symbol     (req_symbol),
      .req_from_state (req_from_state),
      .req_to_state   (req_to_state),
      .start_state    (start_state),
      .final_mask     (final_mask),
      .restart        (restart),
      .restart_state  (restart_state),
      .clear_busy     (clear_busy),
      .out_free       (out_free),
      .fin            (fin),
      .mem_ctl        (mem_ctl),
      .alpha_addr     (alpha_addr),
      .tbl_addr       (tbl_addr),
      .tbl_wdata      (tbl_wdata),
      .alpha_rdata    (alpha_rdata),
      .tbl_rdata      (tbl_rdata)
   );

   // output register is free when empty or drained this cycle
   assign out_free = !rsp_valid_ff || !rsp_stall;

   // result output register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (fin.valid) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
      if (fin.valid) begin
         rsp_status_ff   <= fin.status;
         rsp_accepted_ff <= fin.accepted;
      end
   end

   assign rsp_valid    = rsp_valid_ff;
   assign rsp_status   = rsp_status_ff;
   assign rsp_accepted = rsp_accepted_ff;

endmodule
